// File: design/chm_pkg.sv
package chm_pkg;

    // default sizes
    localparam int unsigned BUCKETS_DEF    = 431;
    localparam int unsigned POOL_NODES_DEF = 1024;

    // field widths
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VALUE_W = 64;

    // hash multiplier and the reduction digit size
    localparam int unsigned MUL_W      = 10;
    localparam logic [MUL_W-1:0] HASH_MUL = 10'd997;
    localparam int unsigned DIGIT_BITS = 4;

    // operation codes
    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_STORED    = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

// File: design/chained_hash_map.sv
// a put on a full pool is answered without the hash step
// throughput: one item at a time; the bucket remainder unit and the
//   one-node-per-cycle chain walk over the node memory read port set the rate
// reset: asynchronous, active low; a clearing pass then empties all BUCKETS
//   entries of the bucket table (431 by default) before in_ready rises
module chained_hash_map #(
    parameter int unsigned BUCKETS    = chm_pkg::BUCKETS_DEF,
    parameter int unsigned POOL_NODES = chm_pkg::POOL_NODES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [chm_pkg::KEY_W-1:0]     key,
    input  logic [chm_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [chm_pkg::VALUE_W-1:0]   found_value
);

    localparam int unsigned NW = $clog2(POOL_NODES + 1);
    localparam int unsigned AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_HASH   = 7'b0000100,
        S_BRD    = 7'b0001000,
        S_BUCKET = 7'b0010000,
        S_LINK   = 7'b0100000,
        S_NCMP   = 7'b1000000
    } state_t;

    // S_RESP folded: result waits in res regs, pend_reg marks it
    state_t                         state_reg, state_next;
    logic [BW-1:0]                  clr_reg, clr_next;
    logic [NW-1:0]                  used_reg, used_next;
    logic [NW-1:0]                  node_reg, node_next_v;
    logic [NW-1:0]                  link_reg, link_next;
    logic                           op_reg;
    logic [chm_pkg::KEY_W-1:0]      key_reg;
    logic [chm_pkg::VALUE_W-1:0]    value_reg;
    logic                           pend_reg, pend_next;
    chm_pkg::status_t               res_status_reg, res_status_next;
    logic [chm_pkg::VALUE_W-1:0]    res_value_reg, res_value_next;
    logic                           out_valid_reg;
    chm_pkg::status_t               status_reg;
    logic [chm_pkg::VALUE_W-1:0]    found_value_reg;

    logic                           accept;
    logic                           full_put;
    logic                           hash_start;
    logic                           hash_done;
    logic [BW-1:0]                  hash_bucket;

    // bucket table: head and tail per bucket
    logic [2*NW-1:0]                bkt_mem [BUCKETS];
    logic [2*NW-1:0]                bkt_q;
    logic                           bkt_we, bkt_re;
    logic [BW-1:0]                  bkt_waddr;
    logic [2*NW-1:0]                bkt_wdata;
    logic [NW-1:0]                  head, tail;

    // node pool
    logic [chm_pkg::KEY_W-1:0]      nkey_mem [POOL_NODES];
    logic [chm_pkg::VALUE_W-1:0]    nval_mem [POOL_NODES];
    logic [NW-1:0]                  nnext_mem [POOL_NODES];
    logic [chm_pkg::KEY_W-1:0]      nkey_q;
    logic [chm_pkg::VALUE_W-1:0]    nval_q;
    logic [NW-1:0]                  nnext_q;
    logic                           nkv_we, nnext_we, nrd_en;
    logic [AW-1:0]                  nnext_waddr, nrd_addr;
    logic [NW-1:0]                  nnext_wdata;

    assign head = bkt_q[2*NW-1:NW];
    assign tail = bkt_q[NW-1:0];

    assign in_ready   = (state_reg == S_IDLE) && !pend_reg;
    assign accept     = in_valid && in_ready;
    assign full_put   = (op == chm_pkg::OP_PUT) && (used_reg == NIL);
    assign hash_start = accept && !full_put;

    chm_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (key),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        used_next       = used_reg;
        node_next_v     = node_reg;
        link_next       = link_reg;
        pend_next       = pend_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        bkt_we          = 1'b0;
        bkt_re          = 1'b0;
        bkt_waddr       = hash_bucket;
        bkt_wdata       = {NIL, NIL};
        nkv_we          = 1'b0;
        nnext_we        = 1'b0;
        nnext_waddr     = used_reg[AW-1:0];
        nnext_wdata     = NIL;
        nrd_en          = 1'b0;
        nrd_addr        = nnext_q[AW-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == BW'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (full_put)
                    begin
                        res_status_next = chm_pkg::ST_FULL;
                        res_value_next  = '0;
                        pend_next       = 1'b1;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_BRD;
                end
            end
            S_BRD:
            begin
                bkt_re     = 1'b1;
                state_next = S_BUCKET;
            end
            S_BUCKET:
            begin
                if (op_reg == chm_pkg::OP_PUT)
                begin
                    // new node at the pool's next slot, appended to the chain
                    nkv_we          = 1'b1;
                    nnext_we        = 1'b1;
                    bkt_we          = 1'b1;
                    node_next_v     = used_reg;
                    link_next       = tail;
                    used_next       = used_reg + 1'b1;
                    res_status_next = chm_pkg::ST_STORED;
                    res_value_next  = '0;
                    if (tail < used_reg)
                    begin
                        bkt_wdata  = {head, used_reg};
                        state_next = S_LINK;
                    end
                    else
                    begin
                        bkt_wdata  = {used_reg, used_reg};
                        pend_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (head < used_reg)
                begin
                    nrd_en     = 1'b1;
                    nrd_addr   = head[AW-1:0];
                    state_next = S_NCMP;
                end
                else
                begin
                    res_status_next = chm_pkg::ST_NOT_FOUND;
                    res_value_next  = '0;
                    pend_next       = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_LINK:
            begin
                nnext_we    = 1'b1;
                nnext_waddr = link_reg[AW-1:0];
                nnext_wdata = node_reg;
                pend_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_NCMP:
            begin
                // compare one node, and fetch the next one on a miss
                if (nkey_q == key_reg)
                begin
                    res_status_next = chm_pkg::ST_FOUND;
                    res_value_next  = nval_q;
                    pend_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (nnext_q < used_reg)
                begin
                    nrd_en = 1'b1;
                end
                else
                begin
                    res_status_next = chm_pkg::ST_NOT_FOUND;
                    res_value_next  = '0;
                    pend_next       = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // pending result moves to the output register when it is free
        if (pend_reg && (!out_valid_reg || out_ready))
        begin
            pend_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            used_reg  <= used_next;
            pend_reg  <= pend_next;
            if (pend_reg && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        node_reg       <= node_next_v;
        link_reg       <= link_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if (accept)
        begin
            op_reg    <= op;
            key_reg   <= key;
            value_reg <= value;
        end
        if (pend_reg && (!out_valid_reg || out_ready))
        begin
            status_reg      <= res_status_reg;
            found_value_reg <= res_value_reg;
        end
    end

    // bucket table memory
    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        if (bkt_re)
        begin
            bkt_q <= bkt_mem[hash_bucket];
        end
    end

    // node key and value memories
    always_ff @(posedge clk)
    begin
        if (nkv_we)
        begin
            nkey_mem[used_reg[AW-1:0]] <= key_reg;
            nval_mem[used_reg[AW-1:0]] <= value_reg;
        end
        if (nrd_en)
        begin
            nkey_q <= nkey_mem[nrd_addr];
            nval_q <= nval_mem[nrd_addr];
        end
    end

    // node link memory
    always_ff @(posedge clk)
    begin
        if (nnext_we)
        begin
            nnext_mem[nnext_waddr] <= nnext_wdata;
        end
        if (nrd_en)
        begin
            nnext_q <= nnext_mem[nrd_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_value = found_value_reg;

endmodule

// File: design/chm_hash.sv
module chm_hash #(
    parameter int unsigned BUCKETS = chm_pkg::BUCKETS_DEF,
    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [chm_pkg::KEY_W-1:0]  key,
    output logic                       done,
    output logic [BW-1:0]              bucket
);

    localparam int unsigned RW      = BW + 1;
    localparam int unsigned STEPS   = chm_pkg::KEY_W / chm_pkg::DIGIT_BITS;
    localparam int unsigned CW      = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int unsigned PROD_W  = chm_pkg::KEY_W + chm_pkg::MUL_W;
    localparam logic [RW-1:0] BKT_R = RW'(BUCKETS);

    typedef enum logic [1:0] {
        H_IDLE = 2'b01,
        H_MOD  = 2'b10
    } hstate_t;

    hstate_t                    state_reg, state_next;
    logic [chm_pkg::KEY_W-1:0]  prod_reg, prod_next;
    logic [RW-1:0]              rem_reg, rem_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       done_reg, done_next;
    logic [PROD_W-1:0]          mul_full;
    logic [RW-1:0]              rem_step;

    // key times multiplier, low word kept
    assign mul_full = PROD_W'(key) * PROD_W'(chm_pkg::HASH_MUL);

    // remainder by the bucket count, one digit of the product per cycle
    always_comb
    begin
        rem_step = rem_reg;
        for (int i = 0; i < int'(chm_pkg::DIGIT_BITS); i++)
        begin
            rem_step = {rem_step[RW-2:0], prod_reg[chm_pkg::KEY_W-1-i]};
            if (rem_step >= BKT_R)
            begin
                rem_step = rem_step - BKT_R;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    prod_next  = mul_full[chm_pkg::KEY_W-1:0];
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = H_MOD;
                end
            end
            H_MOD:
            begin
                rem_next  = rem_step;
                prod_next = prod_reg << chm_pkg::DIGIT_BITS;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(STEPS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign done   = done_reg;
    assign bucket = rem_reg[BW-1:0];

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import chm_pkg::*;

    localparam int unsigned BUCKET_COUNT     = BUCKETS_DEF;
    localparam int unsigned NODE_COUNT       = POOL_NODES_DEF;
    localparam int unsigned NO_NODE          = NODE_COUNT;
    localparam int unsigned HOT_KEYS         = 32;
    localparam int unsigned RANDOM_PER_PHASE = 520;
    localparam int unsigned DRAIN_CYCLES     = 64;
    localparam int unsigned CYCLE_LIMIT      = 600000;

    typedef struct packed {
        status_t            st;
        logic [VALUE_W-1:0] val;
    } map_result_t;

    typedef struct packed {
        logic               op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] val;
        logic               known;
        status_t            st;
        logic [VALUE_W-1:0] res;
    } map_request_t;

    // clock, reset and block ports
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic               op        = OP_PUT;
    logic [KEY_W-1:0]   key       = '0;
    logic [VALUE_W-1:0] value     = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic [VALUE_W-1:0] found_value;

    // shadow copy of the map
    int unsigned        chain_head  [BUCKET_COUNT];
    int unsigned        chain_tail  [BUCKET_COUNT];
    logic [KEY_W-1:0]   node_keys   [NODE_COUNT];
    logic [VALUE_W-1:0] node_values [NODE_COUNT];
    int unsigned        node_links  [NODE_COUNT];
    int unsigned        nodes_taken;

    map_result_t        expected_results [$];
    map_request_t       directed_rows    [$];
    logic [KEY_W-1:0]   stored_keys      [$];
    logic [KEY_W-1:0]   hot_keys         [HOT_KEYS];

    int unsigned        sender_idle_pct   = 27;
    int unsigned        receiver_idle_pct = 60;
    int unsigned        error_count       = 0;
    int unsigned        cycle_count       = 0;

    chained_hash_map i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_value (found_value)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // bucket index: low 32 bits of key times the multiplier, then modulo
    function automatic int unsigned bucket_of_key(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] mul;
        logic [KEY_W-1:0] prod;
        mul  = HASH_MUL;
        prod = k * mul;
        return prod % BUCKET_COUNT;
    endfunction

    // apply one put or get to the shadow map and return its answer
    function automatic map_result_t hash_map_step(logic op_in, logic [KEY_W-1:0] k,
                                                  logic [VALUE_W-1:0] v);
        map_result_t r;
        int unsigned b;
        int unsigned cur;
        int unsigned steps;
        r.st  = ST_NOT_FOUND;
        r.val = '0;
        b     = bucket_of_key(k);
        if (op_in == OP_PUT)
        begin
            if (nodes_taken >= NODE_COUNT)
            begin
                r.st = ST_FULL;
            end
            else
            begin
                node_keys[nodes_taken]   = k;
                node_values[nodes_taken] = v;
                node_links[nodes_taken]  = NO_NODE;
                // link behind the current tail, or start the chain
                if (chain_tail[b] < nodes_taken)
                    node_links[chain_tail[b]] = nodes_taken;
                else
                    chain_head[b] = nodes_taken;
                chain_tail[b] = nodes_taken;
                nodes_taken++;
                r.st = ST_STORED;
            end
        end
        else
        begin
            // walk from the head, oldest node first
            cur   = chain_head[b];
            steps = 0;
            while (cur < nodes_taken && steps < NODE_COUNT && r.st != ST_FOUND)
            begin
                if (node_keys[cur] == k)
                begin
                    r.st  = ST_FOUND;
                    r.val = node_values[cur];
                end
                else
                begin
                    cur = node_links[cur];
                    steps++;
                end
            end
        end
        return r;
    endfunction

    task automatic add_row(logic op_in, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v,
                           logic known, status_t st, logic [VALUE_W-1:0] res);
        map_request_t row;
        row.op    = op_in;
        row.key   = k;
        row.val   = v;
        row.known = known;
        row.st    = st;
        row.res   = res;
        directed_rows.push_back(row);
    endtask

    // present one item, hold it until the transfer, then record what it should answer
    task automatic send_request(logic op_in, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v,
                                logic known, status_t st, logic [VALUE_W-1:0] res);
        map_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_in;
        key      <= k;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = hash_map_step(op_in, k, v);
        if (known)
        begin
            predicted.st  = st;
            predicted.val = res;
        end
        expected_results.push_back(predicted);
        if (op_in == OP_PUT && predicted.st == ST_STORED)
            stored_keys.push_back(k);
    endtask

    // random item: mostly repeated and colliding keys so chains grow and get walked
    task automatic send_random_request();
        logic               op_r;
        logic [KEY_W-1:0]   k;
        logic [VALUE_W-1:0] v;
        int unsigned        pick;
        op_r = ($urandom_range(99) < 78) ? OP_PUT : OP_GET;
        pick = $urandom_range(99);
        if (op_r == OP_PUT)
        begin
            if (pick < 40)
                k = hot_keys[$urandom_range(HOT_KEYS - 1)];
            else if (pick < 50)
                k = BUCKET_COUNT * $urandom_range(40, 1);
            else
                k = $urandom;
        end
        else
        begin
            if (pick < 45 && stored_keys.size() != 0)
                k = stored_keys[$urandom_range(stored_keys.size() - 1)];
            else if (pick < 65)
                k = hot_keys[$urandom_range(HOT_KEYS - 1)];
            else if (pick < 75)
                k = BUCKET_COUNT * $urandom_range(40, 1);
            else
                k = $urandom;
        end
        v = {$urandom, $urandom};
        send_request(op_r, k, v, 1'b0, ST_STORED, '0);
    endtask

    // hold off the sender until every outstanding result is back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // result side: check each transfer, then pick the next ready
    always @(posedge clk)
    begin
        map_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d value %h",
                         $time, status, found_value);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.st)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.st, status);
                    error_count++;
                end
                if (found_value !== want.val)
                begin
                    $display("%0t: found_value mismatch, expected %h actual %h",
                             $time, want.val, found_value);
                    error_count++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned phase;
        for (n = 0; n < BUCKET_COUNT; n++)
        begin
            chain_head[n] = NO_NODE;
            chain_tail[n] = NO_NODE;
        end
        for (n = 0; n < NODE_COUNT; n++)
        begin
            node_keys[n]   = '0;
            node_values[n] = '0;
            node_links[n]  = NO_NODE;
        end
        nodes_taken = 0;
        for (n = 0; n < HOT_KEYS; n++)
            hot_keys[n] = $urandom;

        // directed: empty map, extreme keys and values, duplicates, shared bucket
        add_row(OP_GET, 32'h0000_0000, 64'h0, 1'b1, ST_NOT_FOUND, 64'h0);
        add_row(OP_GET, 32'hffff_ffff, '1, 1'b1, ST_NOT_FOUND, 64'h0);
        add_row(OP_PUT, 32'h0000_0000, 64'h0, 1'b1, ST_STORED, 64'h0);
        add_row(OP_PUT, 32'hffff_ffff, '1, 1'b1, ST_STORED, 64'h0);
        add_row(OP_GET, 32'h0000_0000, 64'h0, 1'b1, ST_FOUND, 64'h0);
        add_row(OP_GET, 32'hffff_ffff, 64'h0, 1'b1, ST_FOUND, '1);
        add_row(OP_PUT, 32'h0000_0000, 64'h1234_5678_9abc_def0, 1'b1, ST_STORED, 64'h0);
        add_row(OP_GET, 32'h0000_0000, 64'hffff, 1'b1, ST_FOUND, 64'h0);
        add_row(OP_PUT, 32'd431, 64'ha5a5_a5a5_a5a5_a5a5, 1'b1, ST_STORED, 64'h0);
        add_row(OP_GET, 32'd431, 64'h0, 1'b1, ST_FOUND, 64'ha5a5_a5a5_a5a5_a5a5);
        add_row(OP_GET, 32'd862, 64'h0, 1'b1, ST_NOT_FOUND, 64'h0);
        add_row(OP_PUT, 32'h8000_0000, 64'h8000_0000_0000_0000, 1'b1, ST_STORED, 64'h0);
        add_row(OP_GET, 32'h8000_0000, 64'h0, 1'b0, ST_STORED, 64'h0);
        add_row(OP_PUT, 32'h0000_0001, 64'h5a5a_5a5a_5a5a_5a5a, 1'b0, ST_STORED, 64'h0);
        add_row(OP_GET, 32'h0000_0001, 64'h0, 1'b0, ST_STORED, 64'h0);
        add_row(OP_GET, 32'h7fff_ffff, 64'h0, 1'b0, ST_STORED, 64'h0);
        add_row(OP_PUT, 32'hdead_beef, 64'h0123_4567_89ab_cdef, 1'b0, ST_STORED, 64'h0);
        add_row(OP_PUT, 32'hdead_beef, 64'hfedc_ba98_7654_3210, 1'b0, ST_STORED, 64'h0);
        add_row(OP_GET, 32'hdead_beef, 64'h0, 1'b0, ST_STORED, 64'h0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].val,
                         directed_rows[i].known, directed_rows[i].st, directed_rows[i].res);
        wait_for_drain();

        // random phases: receiver idles more, then sender idles more, then neither
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct   = 27;
                    receiver_idle_pct = 60;
                end
                1:
                begin
                    sender_idle_pct   = 60;
                    receiver_idle_pct = 27;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                send_random_request();
                if ($urandom_range(119) == 0)
                    wait_for_drain();
            end
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
